// ===== rtl/ppt_pkg.sv =====
// Shared types and constants for the pulse period tachometer.
// Used by every module in rtl/; depends on nothing else.

package ppt_pkg;

    // Field and datapath widths
    localparam int TIME_W  = 32;
    localparam int PPR_W   = 8;
    localparam int RPM_W   = 16;
    localparam int PROD_W  = TIME_W + PPR_W;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_REV   = 2'd2;

    // Configuration reset values
    localparam logic [TIME_W-1:0] MIN_INTERVAL_RST = 32'd2000;
    localparam logic [TIME_W-1:0] STOP_TIMEOUT_RST = 32'd1000000;
    localparam logic [PPR_W-1:0]  PULSES_REV_RST   = 8'd1;

    // Rpm = NUMERATOR / (interval * marks), saturated
    localparam logic [PROD_W-1:0] RPM_NUMERATOR = 40'd60000000;
    localparam logic [RPM_W-1:0]  RPM_MAX       = 16'hFFFF;
    // Partial remainder before the first quotient bit
    localparam logic [PROD_W-1:0] DIV_INIT      = RPM_NUMERATOR >> RPM_W;
    // Smallest divisor whose quotient fits in RPM_W bits
    localparam logic [PROD_W-1:0] SAT_LIMIT     = DIV_INIT + 40'd1;

    // Step counts of the serial units
    localparam int SER_STEPS = TIME_W;
    localparam int MUL_STEPS = PPR_W;
    localparam int DIV_STEPS = RPM_W;
    localparam int CNT_W     = $clog2(SER_STEPS);

    // Load / step strobes for a serial unit
    typedef struct packed {
        logic load;
        logic step;
    } ppt_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SERIAL,
        ST_DECIDE,
        ST_DIVIDE,
        ST_FINISH
    } ppt_state_t;

endpackage

// ===== rtl/ppt_serial_sub.sv =====
// Bit-serial subtractor and threshold compare: diff = a - b, at_least = diff >= t.
// One bit per cycle while stepped, LSB first. Depends on ppt_pkg.

module ppt_serial_sub (
    input  logic                         clk,
    input  ppt_pkg::ppt_ctl_t            ctl,
    input  logic [ppt_pkg::TIME_W-1:0]   minuend,
    input  logic [ppt_pkg::TIME_W-1:0]   subtrahend,
    input  logic [ppt_pkg::TIME_W-1:0]   threshold,
    output logic [ppt_pkg::TIME_W-1:0]   operand,
    output logic [ppt_pkg::TIME_W-1:0]   diff,
    output logic                         at_least
);

    logic [ppt_pkg::TIME_W-1:0] a_reg;
    logic [ppt_pkg::TIME_W-1:0] b_reg;
    logic [ppt_pkg::TIME_W-1:0] t_reg;
    logic [ppt_pkg::TIME_W-1:0] d_reg;
    logic                       bw_diff_reg;
    logic                       bw_cmp_reg;

    logic d_bit;
    logic bw_diff_next;
    logic bw_cmp_next;

    // One full-subtractor cell for each chain
    always_comb
    begin
        d_bit        = a_reg[0] ^ b_reg[0] ^ bw_diff_reg;
        bw_diff_next = (~a_reg[0] & b_reg[0]) | (~(a_reg[0] ^ b_reg[0]) & bw_diff_reg);
        bw_cmp_next  = (~d_bit & t_reg[0]) | (~(d_bit ^ t_reg[0]) & bw_cmp_reg);
    end

    // Operand a rotates so it is intact after a full pass
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg       <= minuend;
            b_reg       <= subtrahend;
            t_reg       <= threshold;
            bw_diff_reg <= 1'b0;
            bw_cmp_reg  <= 1'b0;
        end
        else if (ctl.step)
        begin
            a_reg       <= {a_reg[0], a_reg[ppt_pkg::TIME_W-1:1]};
            b_reg       <= {1'b0, b_reg[ppt_pkg::TIME_W-1:1]};
            t_reg       <= {1'b0, t_reg[ppt_pkg::TIME_W-1:1]};
            d_reg       <= {d_bit, d_reg[ppt_pkg::TIME_W-1:1]};
            bw_diff_reg <= bw_diff_next;
            bw_cmp_reg  <= bw_cmp_next;
        end
    end

    assign operand  = a_reg;
    assign diff     = d_reg;
    assign at_least = ~bw_cmp_reg;

endmodule

// ===== rtl/ppt_serial_mul.sv =====
// Shift-and-add multiplier: interval times marks per revolution, one mark bit a cycle.
// Depends on ppt_pkg.

module ppt_serial_mul (
    input  logic                         clk,
    input  ppt_pkg::ppt_ctl_t            ctl,
    input  logic [ppt_pkg::TIME_W-1:0]   multiplicand,
    input  logic [ppt_pkg::PPR_W-1:0]    multiplier,
    output logic [ppt_pkg::PROD_W-1:0]   product
);

    logic [ppt_pkg::PROD_W-1:0] mcand_reg;
    logic [ppt_pkg::PPR_W-1:0]  mplier_reg;
    logic [ppt_pkg::PROD_W-1:0] acc_reg;

    // Zero marks count as one
    logic [ppt_pkg::PPR_W-1:0] marks;
    assign marks = (multiplier == '0) ? ppt_pkg::PPR_W'(1) : multiplier;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mcand_reg  <= {{ppt_pkg::PPR_W{1'b0}}, multiplicand};
            mplier_reg <= marks;
            acc_reg    <= '0;
        end
        else if (ctl.step)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[ppt_pkg::PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[ppt_pkg::PPR_W-1:1]};
        end
    end

    assign product = acc_reg;

endmodule

// ===== rtl/ppt_serial_div.sv =====
// Restoring divider: constant numerator by a 40-bit divisor, one quotient bit a cycle.
// Valid when divisor >= SAT_LIMIT; depends on ppt_pkg.

module ppt_serial_div (
    input  logic                         clk,
    input  ppt_pkg::ppt_ctl_t            ctl,
    input  logic [ppt_pkg::PROD_W-1:0]   divisor,
    output logic [ppt_pkg::RPM_W-1:0]    quotient
);

    logic [ppt_pkg::PROD_W-1:0] dvs_reg;
    logic [ppt_pkg::PROD_W-1:0] rem_reg;
    logic [ppt_pkg::RPM_W-1:0]  num_reg;
    logic [ppt_pkg::RPM_W-1:0]  q_reg;

    logic [ppt_pkg::PROD_W:0] trial;
    logic [ppt_pkg::PROD_W:0] trial_sub;
    logic                     fits;

    // Bring down the next numerator bit and try the subtract
    always_comb
    begin
        trial     = {rem_reg, num_reg[ppt_pkg::RPM_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            dvs_reg <= divisor;
            rem_reg <= ppt_pkg::DIV_INIT;
            num_reg <= ppt_pkg::RPM_NUMERATOR[ppt_pkg::RPM_W-1:0];
            q_reg   <= '0;
        end
        else if (ctl.step)
        begin
            rem_reg <= fits ? trial_sub[ppt_pkg::PROD_W-1:0] : trial[ppt_pkg::PROD_W-1:0];
            num_reg <= {num_reg[ppt_pkg::RPM_W-2:0], 1'b0};
            q_reg   <= {q_reg[ppt_pkg::RPM_W-2:0], fits};
        end
    end

    assign quotient = q_reg;

endmodule

// ===== rtl/pulse_period_tachometer.sv =====
// Pulse period tachometer top level: control sequencer, config and output registers.
// Instantiates ppt_serial_sub, ppt_serial_mul, ppt_serial_div; depends on ppt_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall, op, timestamp_us): op = 0 reports a pulse
//   edge, op = 1 requests a speed reading. A pulse edge gives no result; a read
//   gives one rpm value on the output channel (out_valid/out_stall, rpm).
//   Config port (cfg_we, cfg_index, cfg_data): 0 = min interval, 1 = stopped
//   timeout, 2 = pulses per revolution; index 3 is ignored. Write only when idle.
// Sequence:
//   A transaction runs through a bit-serial subtract/compare (the shift-add
//   multiply overlaps it) and then a decision state. A pulse edge drops
//   in_stall when the sequencer returns to idle after the decision; a read adds
//   a restoring divide and a load into the output register, which waits while
//   the output is stalled, and the next transaction can be taken in the cycle
//   rpm becomes valid. One transaction is processed at a time.
// Reset: config returns to 2000 us / 1000000 us / 1 pulse, stored pulse time
//   and interval clear to zero, output register empties.
// Stall: a waiting result sits in the output register while the next
//   transaction is taken; a newer result waits in the finish step until the
//   output register is free.

module pulse_period_tachometer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [ppt_pkg::TIME_W-1:0]        timestamp_us,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ppt_pkg::RPM_W-1:0]         rpm,
    input  logic                              cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppt_pkg::TIME_W-1:0]        cfg_data
);

    ppt_pkg::ppt_state_t state_reg;
    ppt_pkg::ppt_state_t state_next;

    logic [ppt_pkg::CNT_W-1:0]  cnt_reg;
    logic                       op_reg;

    logic [ppt_pkg::TIME_W-1:0] min_interval_reg;
    logic [ppt_pkg::TIME_W-1:0] stop_timeout_reg;
    logic [ppt_pkg::PPR_W-1:0]  pulses_rev_reg;

    logic [ppt_pkg::TIME_W-1:0] last_pulse_reg;
    logic [ppt_pkg::TIME_W-1:0] interval_reg;

    logic                       out_valid_reg;
    logic [ppt_pkg::RPM_W-1:0]  rpm_reg;
    logic [ppt_pkg::RPM_W-1:0]  rpm_next;

    logic accept;
    logic commit;
    logic out_load;
    logic ser_last;
    logic div_last;

    ppt_pkg::ppt_ctl_t sub_ctl;
    ppt_pkg::ppt_ctl_t mul_ctl;
    ppt_pkg::ppt_ctl_t div_ctl;

    logic [ppt_pkg::TIME_W-1:0] sub_operand;
    logic [ppt_pkg::TIME_W-1:0] sub_diff;
    logic                       sub_at_least;
    logic [ppt_pkg::PROD_W-1:0] product;
    logic [ppt_pkg::RPM_W-1:0]  quotient;
    logic [ppt_pkg::TIME_W-1:0] threshold;

    assign accept   = in_valid && !in_stall;
    assign ser_last = (cnt_reg == ppt_pkg::CNT_W'(ppt_pkg::SER_STEPS - 1));
    assign div_last = (cnt_reg == ppt_pkg::CNT_W'(ppt_pkg::DIV_STEPS - 1));

    // Reads compare the age against the timeout, edges the gap against the minimum
    assign threshold = (op == ppt_pkg::OP_READ) ? stop_timeout_reg : min_interval_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ppt_pkg::ST_SERIAL;
                end
            end
            ppt_pkg::ST_SERIAL:
            begin
                if (ser_last)
                begin
                    state_next = ppt_pkg::ST_DECIDE;
                end
            end
            ppt_pkg::ST_DECIDE:
            begin
                state_next = (op_reg == ppt_pkg::OP_READ) ? ppt_pkg::ST_DIVIDE
                                                          : ppt_pkg::ST_IDLE;
            end
            ppt_pkg::ST_DIVIDE:
            begin
                if (div_last)
                begin
                    state_next = ppt_pkg::ST_FINISH;
                end
            end
            ppt_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ppt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall     = 1'b1;
        sub_ctl      = '0;
        mul_ctl      = '0;
        div_ctl      = '0;
        commit       = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ppt_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                sub_ctl.load = in_valid;
                mul_ctl.load = in_valid;
            end
            ppt_pkg::ST_SERIAL:
            begin
                sub_ctl.step = 1'b1;
                mul_ctl.step = (cnt_reg < ppt_pkg::CNT_W'(ppt_pkg::MUL_STEPS));
            end
            ppt_pkg::ST_DECIDE:
            begin
                div_ctl.load = (op_reg == ppt_pkg::OP_READ);
                commit       = (op_reg == ppt_pkg::OP_PULSE) && sub_at_least;
            end
            ppt_pkg::ST_DIVIDE:
            begin
                div_ctl.step = 1'b1;
            end
            ppt_pkg::ST_FINISH:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Sequencer state, step counter and latched operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppt_pkg::ST_IDLE;
            cnt_reg   <= '0;
            op_reg    <= ppt_pkg::OP_PULSE;
        end
        else
        begin
            state_reg <= state_next;
            if (accept || state_reg == ppt_pkg::ST_DECIDE)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ppt_pkg::ST_SERIAL || state_reg == ppt_pkg::ST_DIVIDE)
            begin
                cnt_reg <= cnt_reg + ppt_pkg::CNT_W'(1);
            end
            if (accept)
            begin
                op_reg <= op;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= ppt_pkg::MIN_INTERVAL_RST;
            stop_timeout_reg <= ppt_pkg::STOP_TIMEOUT_RST;
            pulses_rev_reg   <= ppt_pkg::PULSES_REV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppt_pkg::CFG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                ppt_pkg::CFG_STOP_TIMEOUT: stop_timeout_reg <= cfg_data;
                ppt_pkg::CFG_PULSES_REV:   pulses_rev_reg   <= cfg_data[ppt_pkg::PPR_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Last accepted pulse: time and interval
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pulse_reg <= '0;
            interval_reg   <= '0;
        end
        else if (commit)
        begin
            last_pulse_reg <= sub_operand;
            interval_reg   <= sub_diff;
        end
    end

    // Result select: stale or no interval reads zero, small divisors saturate
    always_comb
    begin
        priority if (sub_at_least || product == '0)
        begin
            rpm_next = '0;
        end
        else if (product < ppt_pkg::SAT_LIMIT)
        begin
            rpm_next = ppt_pkg::RPM_MAX;
        end
        else
        begin
            rpm_next = quotient;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rpm_reg <= rpm_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign rpm       = rpm_reg;

    // Serial datapath units
    ppt_serial_sub u_sub (
        .clk        (clk),
        .ctl        (sub_ctl),
        .minuend    (timestamp_us),
        .subtrahend (last_pulse_reg),
        .threshold  (threshold),
        .operand    (sub_operand),
        .diff       (sub_diff),
        .at_least   (sub_at_least)
    );

    ppt_serial_mul u_mul (
        .clk          (clk),
        .ctl          (mul_ctl),
        .multiplicand (interval_reg),
        .multiplier   (pulses_rev_reg),
        .product      (product)
    );

    ppt_serial_div u_div (
        .clk      (clk),
        .ctl      (div_ctl),
        .divisor  (product),
        .quotient (quotient)
    );

endmodule
